>>> hw/rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// Used by wbps_cell and wildcard_byte_pattern_scan_core; no dependencies.
package wbps_pkg;

  localparam int MAX_PATTERN_LEN_DEF = 16;
  localparam int OFFSET_BITS_DEF     = 32;

  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 5;
  localparam int SEL_W          = 4;
  localparam int CARE_W         = 16;
  localparam int PATTERN_W      = 128;
  localparam int SKIP_W         = 32;
  localparam int MATCH_OFFSET_W = 32;
  localparam int WIDE_W         = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  localparam logic [CARE_W-1:0] CARE_MASK_RESET      = 16'hFFFF;
  localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RESET = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_CARE_MASK      = 3'd2,
    CFG_PATTERN_LENGTH = 3'd3,
    CFG_SKIP_COUNT     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_word_t;

  typedef struct packed {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] match_offset;
  } out_word_t;

  // Per-cell compare setup, to be kept fixed by the user while a region streams through; no check enforces it
  typedef struct packed {
    logic              active;
    logic              care;
    logic [BYTE_W-1:0] pat;
  } cell_cfg_t;

endpackage

>>> hw/rtl/wildcard_byte_pattern_scan_core.sv
// Top level of the wildcard byte pattern scanner: config registers, position
// tracking, the chain of window cells and the match decision stage.
// Depends on wbps_pkg and wbps_cell.
//
// Usage:
//   in_*  : one word per region byte, in address order; last_byte flags the
//           final byte. A word is taken when in_valid is high and in_stall low.
//   out_* : at most one word per region: found with the start offset of the
//           match after skip_count earlier matches, or not-found (offset 0)
//           on the last byte. Taken when out_valid is high and out_stall low.
//   cfg_* : register writes (index, data); cfg_ready is always high. Write
//           only while no region is in flight.
// Throughput: one byte per cycle while no stalled result holds the input.
// Each byte shifts into the cell chain and is compared against all pattern
// positions in parallel in the following cycle. The comparison result and
// the byte's position feed the registered decision stage that drives out_*.
// A stalled result holds the decision stage and every byte behind it; once the
// input stage holds a byte, in_stall stays high until the result is taken.
// Reset: position, match count and region flags clear, the config registers
// return to pattern 0, care mask all ones, length 1, skip count 0.
module wildcard_byte_pattern_scan_core #(
  parameter int MAX_PATTERN_LEN = wbps_pkg::MAX_PATTERN_LEN_DEF,
  parameter int OFFSET_BITS     = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wbps_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wbps_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [wbps_pkg::PATTERN_W-1:0] pattern_r;
  logic [wbps_pkg::CARE_W-1:0]    care_mask_r;
  logic [wbps_pkg::LEN_W-1:0]     pattern_length_r;
  logic [wbps_pkg::SKIP_W-1:0]    skip_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r        <= '0;
      care_mask_r      <= wbps_pkg::CARE_MASK_RESET;
      pattern_length_r <= wbps_pkg::PATTERN_LENGTH_RESET;
      skip_count_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (wbps_pkg::cfg_idx_t'(cfg_index))
        wbps_pkg::CFG_PATTERN_LOW: begin
          pattern_r[wbps_pkg::CFG_DATA_W-1:0] <= cfg_data;
        end
        wbps_pkg::CFG_PATTERN_HIGH: begin
          pattern_r[wbps_pkg::PATTERN_W-1:wbps_pkg::CFG_DATA_W] <= cfg_data;
        end
        wbps_pkg::CFG_CARE_MASK: begin
          care_mask_r <= cfg_data[wbps_pkg::CARE_W-1:0];
        end
        wbps_pkg::CFG_PATTERN_LENGTH: begin
          pattern_length_r <= cfg_data[wbps_pkg::LEN_W-1:0];
        end
        wbps_pkg::CFG_SKIP_COUNT: begin
          skip_count_r <= cfg_data[wbps_pkg::SKIP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective length, clamped to 1..MAX_PATTERN_LEN
  logic [wbps_pkg::LEN_W-1:0] len;
  logic [wbps_pkg::SEL_W-1:0] len_m1;

  always_comb begin
    if (pattern_length_r == '0) begin
      len = wbps_pkg::LEN_W'(1);
    end else if (pattern_length_r > wbps_pkg::LEN_W'(MAX_PATTERN_LEN)) begin
      len = wbps_pkg::LEN_W'(MAX_PATTERN_LEN);
    end else begin
      len = pattern_length_r;
    end
  end

  assign len_m1 = wbps_pkg::SEL_W'(len - wbps_pkg::LEN_W'(1));

  // handshake and pipeline control
  logic in_acc;
  logic adv;
  logic fire;
  logic s1_valid_r;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign fire     = s1_valid_r && adv;

  // byte position within the region, saturating
  logic [OFFSET_BITS-1:0] pos_r;
  logic [OFFSET_BITS-1:0] pos_base;
  logic [OFFSET_BITS-1:0] pos_nxt;
  logic                   last_r;

  assign pos_base = last_r ? '0 : pos_r;
  assign pos_nxt  = (pos_base == '1) ? pos_base : pos_base + OFFSET_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= '0;
      last_r     <= 1'b0;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !adv);
      if (in_acc) begin
        pos_r  <= pos_nxt;
        last_r <= in_data.last_byte;
      end
    end
  end

  // chain of window cells, newest byte in cell 0
  logic [wbps_pkg::BYTE_W-1:0] win [MAX_PATTERN_LEN];
  logic [MAX_PATTERN_LEN-1:0]  eq_vec;
  wbps_pkg::cell_cfg_t         lane_cfg [MAX_PATTERN_LEN];

  for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_cell
    logic [wbps_pkg::SEL_W-1:0] sel;

    // cell k holds age k, which lines up with pattern byte len-1-k
    assign sel                = len_m1 - wbps_pkg::SEL_W'(k);
    assign lane_cfg[k].active = (wbps_pkg::SEL_W'(k) <= len_m1);
    assign lane_cfg[k].care   = care_mask_r[sel];
    assign lane_cfg[k].pat    = pattern_r[sel * wbps_pkg::BYTE_W +: wbps_pkg::BYTE_W];

    if (k == 0) begin : g_head
      wbps_cell u_cell (
        .clk      (clk),
        .shift_en (in_acc),
        .byte_in  (in_data.data_byte),
        .cell_cfg (lane_cfg[k]),
        .byte_out (win[k]),
        .eq       (eq_vec[k])
      );
    end else begin : g_body
      wbps_cell u_cell (
        .clk      (clk),
        .shift_en (in_acc),
        .byte_in  (win[k-1]),
        .cell_cfg (lane_cfg[k]),
        .byte_out (win[k]),
        .eq       (eq_vec[k])
      );
    end
  end

  // decision stage
  logic [wbps_pkg::SKIP_W-1:0]         matches_r;
  logic [wbps_pkg::SKIP_W-1:0]         matches_nxt;
  logic                                finished_r;
  logic                                finished_nxt;
  logic                                hit;
  logic                                live;
  logic                                report;
  logic                                count;
  logic                                not_found;
  logic [OFFSET_BITS-1:0]              diff;
  logic [wbps_pkg::WIDE_W-1:0]         off_wide;
  logic [wbps_pkg::MATCH_OFFSET_W-1:0] match_off;

  assign hit       = (pos_r >= OFFSET_BITS'(len)) && (&eq_vec);
  assign live      = fire && !finished_r;
  assign report    = live && hit && (matches_r >= skip_count_r);
  assign count     = live && hit && (matches_r < skip_count_r);
  assign not_found = live && last_r && !report;

  assign diff      = pos_r - OFFSET_BITS'(len);
  assign off_wide  = wbps_pkg::WIDE_W'(diff);
  assign match_off = off_wide[wbps_pkg::MATCH_OFFSET_W-1:0];

  always_comb begin
    matches_nxt  = matches_r;
    finished_nxt = finished_r;
    if (fire && last_r) begin
      matches_nxt  = '0;
      finished_nxt = 1'b0;
    end else if (count) begin
      matches_nxt = matches_r + wbps_pkg::SKIP_W'(1);
    end else if (report) begin
      finished_nxt = 1'b1;
    end
  end

  logic                out_valid_r;
  wbps_pkg::out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matches_r   <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      matches_r  <= matches_nxt;
      finished_r <= finished_nxt;
      if (adv) begin
        out_valid_r <= report || not_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (report || not_found)) begin
      out_data_r.found        <= report;
      out_data_r.match_offset <= report ? match_off : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input stage");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.match_offset == '0))
    else $error("not-found word carries a nonzero offset");

  a_new_region_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_byte) ##1 in_acc |=> (pos_r == OFFSET_BITS'(1)))
    else $error("position did not restart after a region end");

  a_report_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (report && !last_r) |=> finished_r)
    else $error("region not marked finished after a reported match");
`endif

endmodule

>>> hw/rtl/wbps_cell.sv
// One window cell: holds one byte of the sliding window, hands it on to the
// next cell and compares it with its pattern byte. Depends on wbps_pkg.
module wbps_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [wbps_pkg::BYTE_W-1:0] byte_in,
  input  wbps_pkg::cell_cfg_t       cell_cfg,
  output logic [wbps_pkg::BYTE_W-1:0] byte_out,
  output logic                      eq
);

  logic [wbps_pkg::BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  // unused or wildcard positions always agree
  assign eq = !cell_cfg.active || !cell_cfg.care || (byte_r == cell_cfg.pat);

endmodule
